// ----- rtl/core/iocs_pkg.sv -----
// ----------------------------------------------------------------------------
// iocs_pkg: shared types and constants for the unit completion scheduler
// Field widths, operation codes, register indexes and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package iocs_pkg;

    // field widths
    localparam int TIME_W   = 64;
    localparam int BLOCK_W  = 64;
    localparam int COUNT_W  = 16;
    localparam int BYTE_W   = 26;
    localparam int OP_W     = 2;
    localparam int DELAY_W  = 24;
    localparam int SHIFT_W  = 5;
    localparam int UNITS_W  = 5;

    localparam logic [BYTE_W-1:0] BYTE_MAX = '1;

    // operation codes
    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_UNIT_SHIFT  = 3'd0;
    localparam logic [2:0] REG_UNITS       = 3'd1;
    localparam logic [2:0] REG_RD_SETUP    = 3'd2;
    localparam logic [2:0] REG_RD_CHUNK    = 3'd3;
    localparam logic [2:0] REG_RD_TAIL     = 3'd4;
    localparam logic [2:0] REG_WR_SETUP    = 3'd5;
    localparam logic [2:0] REG_WR_CHUNK    = 3'd6;
    localparam logic [2:0] REG_WR_TAIL     = 3'd7;

    localparam logic [SHIFT_W-1:0] UNIT_SHIFT_RESET = 5'd12;
    localparam logic [UNITS_W-1:0] UNITS_RESET      = 5'd16;

    // unit index remainder: bits consumed per cycle and cycle count
    localparam int DIV_BITS   = 8;
    localparam int DIV_CYCLES = BLOCK_W / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_MAX,
        ST_DELAY,
        ST_CHUNK,
        ST_FLUSH,
        ST_OUT
    } iocs_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/io_unit_completion_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// io_unit_completion_scheduler_top: striped unit completion time scheduler
// Read/write run the divide, table read, max, delay and chunk states (one table
// write per chunk), flush scans the units, other ops go straight to output; one item in
// flight, next taken in the cycle after the result enters the output register.
// Reset sets config to its reset values and clears the table valid bits at once.
// ----------------------------------------------------------------------------
`default_nettype none

module io_unit_completion_scheduler_top
    import iocs_pkg::*;
#(
    parameter int MAX_UNITS   = 16,
    parameter int BLOCK_SHIFT = 9
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // configuration port
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready,
    // input items
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // s_tdata: start_block[63:0], block_count_minus_one[79:64], start_time[143:80]
    input  wire logic [143:0] s_tdata,
    // s_tuser: operation[1:0]
    input  wire logic [1:0]   s_tuser,
    // result items
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // m_tdata: completion_time[63:0], byte_count[89:64], zero[95:90]
    output logic      [95:0]  m_tdata,
    // m_tuser: status[0]
    output logic      [0:0]   m_tuser
);

    localparam int CW = $clog2(MAX_UNITS + 1);
    localparam int IW = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
    localparam int LW = COUNT_W + 1 + BLOCK_SHIFT;

    // configuration registers
    logic [SHIFT_W-1:0] unit_shift_reg;
    logic [UNITS_W-1:0] units_reg;
    logic [DELAY_W-1:0] rd_setup_reg, rd_chunk_reg, rd_tail_reg;
    logic [DELAY_W-1:0] wr_setup_reg, wr_chunk_reg, wr_tail_reg;

    // sequencer and datapath
    iocs_state_t          state_reg, state_next;
    logic [BLOCK_W-1:0]   quo_reg;
    logic [CW-1:0]        mod_rem_reg;
    logic [DIV_CNT_W-1:0] step_reg;
    logic [IW-1:0]        u_reg;
    logic [CW-1:0]        nu_reg;
    logic [CW-1:0]        tail_left_reg;
    logic [CW-1:0]        scan_reg;
    logic                 pend_reg;
    logic [LW-1:0]        chunks_left_reg;
    logic [TIME_W-1:0]    t_reg;
    logic [DELAY_W-1:0]   delay_reg;
    logic [DELAY_W-1:0]   lat_reg;
    logic [DELAY_W:0]     lat_tail_reg;
    logic [BYTE_W-1:0]    bytes_reg;
    logic                 status_reg;

    // busy table
    logic [TIME_W-1:0]    busy_mem [MAX_UNITS];
    logic [MAX_UNITS-1:0] valid_reg;
    logic [TIME_W-1:0]    rd_data_reg;
    logic                 rd_vld_reg;

    // output register
    logic                 m_tvalid_reg;
    logic [95:0]          m_tdata_reg;
    logic                 m_tuser_reg;

    // input decode
    logic [OP_W-1:0]      op_in;
    logic [BLOCK_W-1:0]   blk_in;
    logic [COUNT_W-1:0]   cnt_in;
    logic [TIME_W-1:0]    ts_in;
    logic                 is_rw, is_wr, is_flush;
    logic [SHIFT_W-1:0]   diff;
    logic [LW-1:0]        len_in;
    logic [LW-1:0]        chunk_mask;
    logic [LW-1:0]        chunks_in;
    logic [BYTE_W-1:0]    bytes_in;
    logic [CW-1:0]        nu_now;

    // control
    logic                 accept;
    logic                 div_last;
    logic                 chunk_last;
    logic                 flush_done;
    logic                 load_out;
    logic                 mem_we;
    logic [IW-1:0]        rd_addr;
    logic [TIME_W-1:0]    t_chunk;
    logic [TIME_W-1:0]    mem_wdata;
    logic [TIME_W-1:0]    busy_rd;
    logic [CW-1:0]        u_inc;
    logic [CW-1:0]        div_rem;
    logic [CW:0]          div_trial;
    logic                 cfg_we;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_shift_reg <= UNIT_SHIFT_RESET;
            units_reg      <= UNITS_RESET;
            rd_setup_reg   <= '0;
            rd_chunk_reg   <= '0;
            rd_tail_reg    <= '0;
            wr_setup_reg   <= '0;
            wr_chunk_reg   <= '0;
            wr_tail_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (paddr[4:2])
                REG_UNIT_SHIFT: unit_shift_reg <= pwdata[SHIFT_W-1:0];
                REG_UNITS:      units_reg      <= pwdata[UNITS_W-1:0];
                REG_RD_SETUP:   rd_setup_reg   <= pwdata[DELAY_W-1:0];
                REG_RD_CHUNK:   rd_chunk_reg   <= pwdata[DELAY_W-1:0];
                REG_RD_TAIL:    rd_tail_reg    <= pwdata[DELAY_W-1:0];
                REG_WR_SETUP:   wr_setup_reg   <= pwdata[DELAY_W-1:0];
                REG_WR_CHUNK:   wr_chunk_reg   <= pwdata[DELAY_W-1:0];
                REG_WR_TAIL:    wr_tail_reg    <= pwdata[DELAY_W-1:0];
                default:        ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (paddr[4:2])
            REG_UNIT_SHIFT: prdata = 32'(unit_shift_reg);
            REG_UNITS:      prdata = 32'(units_reg);
            REG_RD_SETUP:   prdata = 32'(rd_setup_reg);
            REG_RD_CHUNK:   prdata = 32'(rd_chunk_reg);
            REG_RD_TAIL:    prdata = 32'(rd_tail_reg);
            REG_WR_SETUP:   prdata = 32'(wr_setup_reg);
            REG_WR_CHUNK:   prdata = 32'(wr_chunk_reg);
            REG_WR_TAIL:    prdata = 32'(wr_tail_reg);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // input decode, evaluated in the accept cycle
    // ------------------------------------------------------------------
    assign op_in    = s_tuser;
    assign blk_in   = s_tdata[63:0];
    assign cnt_in   = s_tdata[79:64];
    assign ts_in    = s_tdata[143:80];
    assign is_wr    = (op_in == OP_WRITE);
    assign is_rw    = (op_in == OP_READ) || is_wr;
    assign is_flush = (op_in == OP_FLUSH);

    // active unit count: zero acts as one, clamp to the table depth
    always_comb
    begin
        if (units_reg == '0)
            nu_now = CW'(1);
        else if (32'(units_reg) > MAX_UNITS)
            nu_now = CW'(MAX_UNITS);
        else
            nu_now = CW'(units_reg);
    end

    // block to chunk shift, none when the chunk is smaller than a block
    assign diff = (32'(unit_shift_reg) > BLOCK_SHIFT)
                  ? SHIFT_W'(32'(unit_shift_reg) - BLOCK_SHIFT) : '0;

    // access length, chunk count (rounded up) and saturated byte count
    assign len_in     = {{BLOCK_SHIFT{1'b0}}, {1'b0, cnt_in} + 17'd1} << BLOCK_SHIFT;
    assign chunk_mask = ~({LW{1'b1}} << unit_shift_reg);
    assign chunks_in  = (len_in >> unit_shift_reg) + LW'((len_in & chunk_mask) != '0);
    assign bytes_in   = (len_in > LW'(BYTE_MAX)) ? BYTE_MAX : len_in[BYTE_W-1:0];

    // ------------------------------------------------------------------
    // unit index remainder, DIV_BITS quotient bits per cycle, MSB first
    // ------------------------------------------------------------------
    always_comb
    begin
        div_rem   = mod_rem_reg;
        div_trial = '0;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            div_trial = {div_rem, quo_reg[BLOCK_W-1-i]};
            if (div_trial >= {1'b0, nu_reg})
                div_trial = div_trial - {1'b0, nu_reg};
            div_rem = div_trial[CW-1:0];
        end
    end

    // chunk loop arithmetic
    assign t_chunk   = t_reg + TIME_W'(lat_reg);
    assign mem_wdata = (tail_left_reg != '0) ? (t_reg + TIME_W'(lat_tail_reg)) : t_chunk;
    assign u_inc     = CW'(u_reg) + CW'(1);
    assign busy_rd   = rd_vld_reg ? rd_data_reg : '0;

    assign div_last   = (step_reg == DIV_CNT_W'(DIV_CYCLES - 1));
    assign chunk_last = (chunks_left_reg == LW'(1));
    assign flush_done = pend_reg && (scan_reg == nu_reg);

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (is_rw)
                        state_next = ST_DIV;
                    else if (is_flush)
                        state_next = ST_FLUSH;
                    else
                        state_next = ST_OUT;
                end
            end
            ST_DIV:   state_next = div_last ? ST_READ : ST_DIV;
            ST_READ:  state_next = ST_MAX;
            ST_MAX:   state_next = ST_DELAY;
            ST_DELAY: state_next = ST_CHUNK;
            ST_CHUNK: state_next = chunk_last ? ST_OUT : ST_CHUNK;
            ST_FLUSH: state_next = flush_done ? ST_OUT : ST_FLUSH;
            ST_OUT:   state_next = (!m_tvalid_reg || m_tready) ? ST_IDLE : ST_OUT;
            default:  state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        s_tready = 1'b0;
        mem_we   = 1'b0;
        load_out = 1'b0;
        rd_addr  = u_reg;
        case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_READ:  rd_addr  = u_reg;
            ST_CHUNK: mem_we   = 1'b1;
            ST_FLUSH: rd_addr  = scan_reg[IW-1:0];
            ST_OUT:   load_out = !m_tvalid_reg || m_tready;
            default:  ;
        endcase
    end

    assign accept = s_tvalid & s_tready;

    // state register and control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            valid_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            if (mem_we)
                valid_reg[u_reg] <= 1'b1;
        end
    end

    // busy table: one write port, one registered read port; reads and
    // writes fall in different states, so no forwarding is needed
    always_ff @(posedge clk)
    begin
        if (mem_we)
            busy_mem[u_reg] <= mem_wdata;
        rd_data_reg <= busy_mem[rd_addr];
        rd_vld_reg  <= valid_reg[rd_addr];
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    quo_reg         <= blk_in >> diff;
                    mod_rem_reg     <= '0;
                    step_reg        <= '0;
                    nu_reg          <= nu_now;
                    tail_left_reg   <= nu_now;
                    scan_reg        <= '0;
                    pend_reg        <= 1'b0;
                    chunks_left_reg <= chunks_in;
                    t_reg           <= is_flush ? '0 : ts_in;
                    delay_reg       <= is_wr ? wr_setup_reg : rd_setup_reg;
                    lat_reg         <= is_wr ? wr_chunk_reg : rd_chunk_reg;
                    lat_tail_reg    <= is_wr ? ({1'b0, wr_chunk_reg} + {1'b0, wr_tail_reg})
                                             : ({1'b0, rd_chunk_reg} + {1'b0, rd_tail_reg});
                    bytes_reg       <= is_rw ? bytes_in : '0;
                    status_reg      <= !(is_rw || is_flush);
                end
            end
            ST_DIV:
            begin
                quo_reg     <= quo_reg << DIV_BITS;
                mod_rem_reg <= div_rem;
                step_reg    <= step_reg + DIV_CNT_W'(1);
                if (div_last)
                    u_reg <= div_rem[IW-1:0];
            end
            ST_MAX:
            begin
                // later of submission time and first unit's busy time
                if (busy_rd > t_reg)
                    t_reg <= busy_rd;
            end
            ST_DELAY:
            begin
                t_reg <= t_reg + TIME_W'(delay_reg);
            end
            ST_CHUNK:
            begin
                t_reg           <= t_chunk;
                chunks_left_reg <= chunks_left_reg - LW'(1);
                if (tail_left_reg != '0)
                    tail_left_reg <= tail_left_reg - CW'(1);
                u_reg <= (u_inc == nu_reg) ? '0 : u_inc[IW-1:0];
            end
            ST_FLUSH:
            begin
                // one read issued per cycle, data compared in the cycle after
                if (scan_reg != nu_reg)
                    scan_reg <= scan_reg + CW'(1);
                pend_reg <= (scan_reg != nu_reg);
                if (pend_reg && (busy_rd > t_reg))
                    t_reg <= busy_rd;
            end
            ST_OUT:
            begin
                if (load_out)
                begin
                    m_tdata_reg <= {6'b0, bytes_reg, t_reg};
                    m_tuser_reg <= status_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

`ifndef SYNTHESIS
    // the round robin pointer stays inside the active units
    a_unit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHUNK) |-> (CW'(u_reg) < nu_reg))
        else $error("unit pointer beyond active units");

    // the flush scan never runs past the active units
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) |-> (scan_reg <= nu_reg))
        else $error("flush scan beyond active units");

    // the chunk loop is never entered with nothing left to do
    a_chunks_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHUNK) |-> (chunks_left_reg != '0))
        else $error("chunk loop with no chunk left");

    // a result leaving the sequencer lands in the output register
    a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (m_tvalid_reg && (state_reg == ST_IDLE)))
        else $error("result not loaded into output register");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/io_unit_completion_scheduler_top_tb.sv -----
// ----------------------------------------------------------------------------
// io_unit_completion_scheduler_top_tb: self-checking bench for the scheduler
// Drives read, write, flush and unsupported items over the input stream and
// programs the timing registers over APB between phases. A shadow scheduler
// with its own unit busy table predicts every result item, which is compared
// field by field on the output stream under random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module io_unit_completion_scheduler_top_tb;
    import iocs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_UNITS    = 16;
    localparam int BLOCK_SHIFT  = 9;
    localparam int SETTLE_CYCLES = 40;
    localparam int LIMIT_CYCLES  = 5_000_000;
    localparam int PRINT_LIMIT   = 50;
    localparam logic [OP_W-1:0] OP_UNSUPPORTED = 2'd3;
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_BAD_OP = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] completion;
        logic [BYTE_W-1:0] bytes;
        logic              status;
    } sched_result_t;

    logic          clk;
    logic          rst_n;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [4:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;
    logic          s_tvalid;
    logic          s_tready;
    // s_tdata: start_block[63:0], block_count_minus_one[79:64], start_time[143:80]
    logic [143:0]  s_tdata;
    // s_tuser: operation[1:0]
    logic [1:0]    s_tuser;
    logic          m_tvalid;
    logic          m_tready;
    // m_tdata: completion_time[63:0], byte_count[89:64], zero[95:90]
    logic [95:0]   m_tdata;
    // m_tuser: status[0]
    logic [0:0]    m_tuser;

    // shadow of the register file and of the unit busy table
    logic [31:0]       shadow_reg [8];
    logic [TIME_W-1:0] unit_busy [MAX_UNITS];

    sched_result_t pending_completions [$];
    int            error_count;
    int            send_idle_pct;
    int            recv_idle_pct;

    io_unit_completion_scheduler_top #(
        .MAX_UNITS   (MAX_UNITS),
        .BLOCK_SHIFT (BLOCK_SHIFT)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // shadow scheduler
    // ------------------------------------------------------------------------

    // unit count with out-of-range values clamped
    function automatic int active_unit_count();
        int n;
        n = int'(shadow_reg[REG_UNITS][UNITS_W-1:0]);
        if (n == 0)
            n = 1;
        if (n > MAX_UNITS)
            n = MAX_UNITS;
        return n;
    endfunction

    function automatic logic [TIME_W-1:0] busy_peak();
        logic [TIME_W-1:0] peak;
        peak = '0;
        for (int i = 0; i < active_unit_count(); i++)
            if (unit_busy[i] > peak)
                peak = unit_busy[i];
        return peak;
    endfunction

    // expected result of one item; updates the shadow busy table
    function automatic sched_result_t schedule_access(input logic [OP_W-1:0] op,
                                                      input logic [BLOCK_W-1:0] blk,
                                                      input logic [COUNT_W-1:0] cnt_m1,
                                                      input logic [TIME_W-1:0] ts);
        sched_result_t     r;
        int                nu;
        int                shift;
        int                diff;
        int                unit;
        logic [63:0]       len;
        logic [63:0]       rem;
        logic [63:0]       size;
        logic [63:0]       chunks;
        logic [63:0]       tailed;
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] setup;
        logic [TIME_W-1:0] chunk_t;
        logic [TIME_W-1:0] tail_t;
        nu = active_unit_count();
        r  = '0;
        case (op)
            OP_READ, OP_WRITE:
            begin
                shift   = int'(shadow_reg[REG_UNIT_SHIFT][SHIFT_W-1:0]);
                size    = 64'd1 << shift;
                len     = (64'(cnt_m1) + 64'd1) << BLOCK_SHIFT;
                rem     = len;
                diff    = (shift > BLOCK_SHIFT) ? shift - BLOCK_SHIFT : 0;
                unit    = int'((blk >> diff) % 64'(nu));
                chunks  = (len + size - 64'd1) >> shift;
                tailed  = (chunks < 64'(nu)) ? chunks : 64'(nu);
                setup   = 64'(shadow_reg[(op == OP_WRITE) ? REG_WR_SETUP : REG_RD_SETUP]);
                chunk_t = 64'(shadow_reg[(op == OP_WRITE) ? REG_WR_CHUNK : REG_RD_CHUNK]);
                tail_t  = 64'(shadow_reg[(op == OP_WRITE) ? REG_WR_TAIL : REG_RD_TAIL]);
                t = ((ts > unit_busy[unit]) ? ts : unit_busy[unit]) + setup;
                do
                begin
                    t = t + chunk_t;
                    unit_busy[unit] = t;
                    // units on the first pass round also carry the trailing time
                    if (tailed > 0)
                    begin
                        unit_busy[unit] = t + tail_t;
                        tailed = tailed - 64'd1;
                    end
                    rem  = rem - ((rem < size) ? rem : size);
                    unit = (unit + 1 >= nu) ? 0 : unit + 1;
                end
                while (rem > 0);
                r.completion = t;
                r.bytes      = (len > 64'(BYTE_MAX)) ? BYTE_MAX : len[BYTE_W-1:0];
                r.status     = STATUS_OK;
            end
            OP_FLUSH:
            begin
                r.completion = busy_peak();
                r.status     = STATUS_OK;
            end
            default:
            begin
                r.completion = ts;
                r.status     = STATUS_BAD_OP;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("%0t mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        sched_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_completions.size() == 0)
                report_mismatch("result item with nothing expected");
            else
            begin
                want = pending_completions.pop_front();
                if (m_tdata[63:0] !== want.completion)
                    report_mismatch($sformatf("completion_time %h, expected %h",
                                              m_tdata[63:0], want.completion));
                if (m_tdata[89:64] !== want.bytes)
                    report_mismatch($sformatf("byte_count %h, expected %h",
                                              m_tdata[89:64], want.bytes));
                if (m_tuser[0] !== want.status)
                    report_mismatch($sformatf("status %b, expected %b",
                                              m_tuser[0], want.status));
            end
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // send one item; leaves tvalid high at the falling edge after acceptance
    task automatic send_item(input logic [OP_W-1:0] op, input logic [BLOCK_W-1:0] blk,
                             input logic [COUNT_W-1:0] cnt_m1, input logic [TIME_W-1:0] ts);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ts, cnt_m1, blk};
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        pending_completions.push_back(schedule_access(op, blk, cnt_m1, ts));
        @(negedge clk);
    endtask

    // hold off until every result is in and the block has settled
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_completions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_UNIT_SHIFT: shadow_reg[idx] = value & 32'h1F;
            REG_UNITS:      shadow_reg[idx] = value & 32'h1F;
            default:        shadow_reg[idx] = value & 32'hFF_FFFF;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_all(input logic [31:0] shift, input logic [31:0] units,
                             input logic [31:0] rd_setup, input logic [31:0] rd_chunk,
                             input logic [31:0] rd_tail, input logic [31:0] wr_setup,
                             input logic [31:0] wr_chunk, input logic [31:0] wr_tail);
        wait_idle();
        write_reg(REG_UNIT_SHIFT, shift);
        write_reg(REG_UNITS, units);
        write_reg(REG_RD_SETUP, rd_setup);
        write_reg(REG_RD_CHUNK, rd_chunk);
        write_reg(REG_RD_TAIL, rd_tail);
        write_reg(REG_WR_SETUP, wr_setup);
        write_reg(REG_WR_CHUNK, wr_chunk);
        write_reg(REG_WR_TAIL, wr_tail);
    endtask

    // ------------------------------------------------------------------------
    // random stimulus helpers
    // ------------------------------------------------------------------------

    function automatic logic [31:0] pick_delay();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'd0;
        if (r == 1)
            return 32'hFF_FFFF;
        if (r < 6)
            return $urandom_range(0, 1000);
        return $urandom & 32'hFF_FFFF;
    endfunction

    task automatic randomize_config();
        logic [31:0] shift;
        logic [31:0] units;
        shift = ($urandom_range(0, 9) < 7) ? $urandom_range(9, 20) : $urandom_range(0, 31);
        units = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 16) : $urandom_range(0, 31);
        write_all(shift, units, pick_delay(), pick_delay(), pick_delay(),
                  pick_delay(), pick_delay(), pick_delay());
    endtask

    // block count kept to a chunk budget; rarely a very long access
    function automatic logic [COUNT_W-1:0] pick_count();
        int      shift;
        longint  budget;
        longint  max_cnt;
        shift  = int'(shadow_reg[REG_UNIT_SHIFT][SHIFT_W-1:0]);
        budget = ($urandom_range(0, 99) == 0) ? 65536 : 64;
        if (shift >= BLOCK_SHIFT)
            max_cnt = (shift - BLOCK_SHIFT >= 11) ? 65536 : budget << (shift - BLOCK_SHIFT);
        else
            max_cnt = budget >> (BLOCK_SHIFT - shift);
        if (max_cnt > 65536)
            max_cnt = 65536;
        if (max_cnt < 1)
            max_cnt = 1;
        if ($urandom_range(0, 1) == 0)
            return COUNT_W'($urandom_range(0, int'((max_cnt < 16) ? max_cnt : 16) - 1));
        return COUNT_W'($urandom_range(0, int'(max_cnt) - 1));
    endfunction

    task automatic random_item();
        int                r;
        logic [OP_W-1:0]   op;
        logic [BLOCK_W-1:0] blk;
        logic [TIME_W-1:0] ts;
        r  = $urandom_range(0, 99);
        op = (r < 40) ? OP_READ : (r < 80) ? OP_WRITE : (r < 92) ? OP_FLUSH : OP_UNSUPPORTED;
        blk = ($urandom_range(0, 1) == 0) ? {$urandom, $urandom} : 64'($urandom_range(0, 255));
        // start time: free, close to the busiest unit, zero, or near wrap-around
        r = $urandom_range(0, 5);
        case (r)
            0, 1:    ts = {$urandom, $urandom};
            2, 3:    ts = busy_peak() + 64'($urandom_range(0, 2000)) - 64'd1000;
            4:       ts = '0;
            default: ts = '1 - 64'($urandom_range(0, 100000));
        endcase
        send_item(op, blk, pick_count(), ts);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // all operations under the register values left by reset
    task automatic test_reset_defaults();
        send_item(OP_READ, '0, '0, '0);
        send_item(OP_WRITE, '1, '1, '1);
        send_item(OP_FLUSH, '0, '0, '0);
        send_item(OP_UNSUPPORTED, {$urandom, $urandom}, 16'h5A5A, {$urandom, $urandom});
    endtask

    // longest access at the smallest legal chunk, timings at maximum, time wrap
    task automatic test_timing_extremes();
        write_all(9, 16, 32'hFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF,
                  32'hFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF);
        send_item(OP_READ, 64'd5, '0, 64'd100);
        send_item(OP_WRITE, 64'd5, 16'd31, '0);
        send_item(OP_READ, 64'd3, '1, '1 - 64'd1000);
        send_item(OP_FLUSH, '1, '1, '1);
        send_item(OP_UNSUPPORTED, '0, '0, '0);
    endtask

    // chunk shifts below a block and beyond range, unit counts out of range
    task automatic test_unit_edge_cases();
        // zero units acts as one, one-byte chunks
        write_all(0, 0, 32'd7, 32'd3, 32'd11, 32'd5, 32'd2, 32'd13);
        send_item(OP_READ, {$urandom, $urandom}, 16'd3, 64'd50);
        send_item(OP_WRITE, 64'd1, '0, '0);
        send_item(OP_FLUSH, '0, '0, '0);
        // unit count above the table size, chunk shift at its top
        write_all(31, 31, 32'd100, 32'd200, 32'd300, 32'd400, 32'd500, 32'd600);
        send_item(OP_READ, '1, '1, {$urandom, $urandom});
        send_item(OP_WRITE, {$urandom, $urandom}, '0, '0);
        send_item(OP_FLUSH, '0, '0, '0);
        // single unit, large chunks, read timings at maximum and write at zero
        write_all(20, 1, 32'hFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF, 0, 0, 0);
        send_item(OP_READ, {$urandom, $urandom}, '1, '0);
        send_item(OP_WRITE, {$urandom, $urandom}, 16'h8000, 64'd1);
        send_item(OP_FLUSH, '0, '0, '0);
        send_item(OP_UNSUPPORTED, '0, '1, '1);
    endtask

    // random traffic under one idling pattern, reprogrammed halfway
    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        randomize_config();
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 2)
                randomize_config();
            else if ($urandom_range(0, 49) == 0)
                wait_idle();
            random_item();
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        m_tready      = 1'b0;
        error_count   = 0;
        send_idle_pct = 13;
        recv_idle_pct = 66;
        for (int i = 0; i < 8; i++)
            shadow_reg[i] = '0;
        shadow_reg[REG_UNIT_SHIFT] = 32'(UNIT_SHIFT_RESET);
        shadow_reg[REG_UNITS]      = 32'(UNITS_RESET);
        for (int i = 0; i < MAX_UNITS; i++)
            unit_busy[i] = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_timing_extremes();
        test_unit_edge_cases();
        test_random_traffic(13, 66, 165);
        test_random_traffic(66, 13, 165);
        test_random_traffic(0, 0, 170);
        wait_idle();

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
